### hw/rtl/sfc_pkg.sv
// Shared types, widths and codes for the sphere/frustum classifier.
package sfc_pkg;

  // Default coordinate width (signed Q12.4 at 16 bits)
  localparam int COORD_WIDTH_DEF = 16;

  // Coefficient format: signed Q2.14
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;

  // Width growth over the coordinate width
  //   accumulator: three products plus shifted translation
  //   view coordinate: accumulator with the Q.14 fraction dropped
  //   plane distance: coefficient times view coordinate, then a difference
  localparam int ACC_EXTRA  = COEF_W + 3;
  localparam int VIEW_EXTRA = ACC_EXTRA - FRAC_BITS;
  localparam int DIST_EXTRA = VIEW_EXTRA + COEF_W + 1;

  // Result fields
  localparam int VIS_W     = 2;
  localparam int DEPTH_W   = 20;
  localparam int DEPTH_MAX = 524287;
  localparam int DEPTH_MIN = -524288;
  localparam int OUT_W     = ((VIS_W + DEPTH_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_W - VIS_W - DEPTH_W;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_XFORM_X   = 3'd0,
    CFG_XFORM_Y   = 3'd1,
    CFG_XFORM_Z   = 3'd2,
    CFG_SIDE      = 3'd3,
    CFG_VERTICAL  = 3'd4,
    CFG_DEPTH_RNG = 3'd5
  } cfg_idx_t;

  typedef enum logic [VIS_W-1:0] {
    VIS_OUTSIDE = 2'd0,
    VIS_INSIDE  = 2'd1,
    VIS_PARTIAL = 2'd2
  } vis_t;

  // One matrix row: three Q2.14 entries (lane 0 lowest) and a Q12.4 translation
  typedef struct packed {
    logic signed [COEF_W-1:0] t;
    logic [2:0][COEF_W-1:0]   m;
  } row_t;

  typedef struct packed {
    row_t row_z;
    row_t row_y;
    row_t row_x;
  } xform_cfg_t;

  // Four Q2.14 plane coefficients, lane 0 lowest
  typedef logic [3:0][COEF_W-1:0] quad_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] far_d;
    logic signed [COEF_W-1:0] near_d;
  } depth_rng_t;

  typedef struct packed {
    depth_rng_t depth;
    quad_t      vertical;
    quad_t      side;
  } plane_cfg_t;

endpackage

### hw/rtl/sfc_xform.sv
// Model-to-view transform: product stage, then sum and floor to Q.4.
module sfc_xform #(
  parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic signed [COORD_WIDTH-1:0]                  center_x,
  input  logic signed [COORD_WIDTH-1:0]                  center_y,
  input  logic signed [COORD_WIDTH-1:0]                  center_z,
  input  logic [COORD_WIDTH-1:0]                         radius,
  input  sfc_pkg::xform_cfg_t                            xform,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic signed [COORD_WIDTH+sfc_pkg::VIEW_EXTRA-1:0] view_x,
  output logic signed [COORD_WIDTH+sfc_pkg::VIEW_EXTRA-1:0] view_y,
  output logic signed [COORD_WIDTH+sfc_pkg::VIEW_EXTRA-1:0] view_z,
  output logic [COORD_WIDTH-1:0]                         radius_out
);
  import sfc_pkg::*;

  localparam int PROD_W = COORD_WIDTH + COEF_W;
  localparam int ACC_W  = COORD_WIDTH + ACC_EXTRA;
  localparam int VIEW_W = COORD_WIDTH + VIEW_EXTRA;

  row_t                     rows     [3];
  logic signed [COORD_WIDTH-1:0] coord [3];
  logic signed [PROD_W-1:0] prod_nxt [3][3];
  logic signed [PROD_W-1:0] prod_r   [3][3];
  logic signed [ACC_W-1:0]  acc      [3];
  logic signed [VIEW_W-1:0] view_r   [3];
  logic [COORD_WIDTH-1:0]   rad1_r;
  logic [COORD_WIDTH-1:0]   rad2_r;
  logic                     s1_valid_r;
  logic                     s2_valid_r;
  logic                     en1;
  logic                     en2;

  assign rows[0]  = xform.row_x;
  assign rows[1]  = xform.row_y;
  assign rows[2]  = xform.row_z;
  assign coord[0] = center_x;
  assign coord[1] = center_y;
  assign coord[2] = center_z;

  // Stage enables: a stage loads when empty or when its contents move on
  assign en2      = !s2_valid_r || out_ready;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;

  // Nine coefficient products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = coord[c] * $signed(rows[r].m[c]);
      end
    end
  end

  // Row sums with translation moved to Q.18
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1]) + ACC_W'(prod_r[r][2])
             + (ACC_W'(rows[r].t) <<< FRAC_BITS);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r <= in_valid;
      if (en2) s2_valid_r <= s1_valid_r;
    end
  end

  // Payload; dropping the low fraction bits floors toward minus infinity
  always_ff @(posedge clk) begin
    if (en1) begin
      prod_r <= prod_nxt;
      rad1_r <= radius;
    end
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        view_r[r] <= acc[r][ACC_W-1:FRAC_BITS];
      end
      rad2_r <= rad1_r;
    end
  end

  assign out_valid  = s2_valid_r;
  assign view_x     = view_r[0];
  assign view_y     = view_r[1];
  assign view_z     = view_r[2];
  assign radius_out = rad2_r;

endmodule

### hw/rtl/sfc_planes.sv
// Plane distances: coefficient products and depth terms, then differences at Q.18.
module sfc_planes #(
  parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic signed [COORD_WIDTH+sfc_pkg::VIEW_EXTRA-1:0] view_x,
  input  logic signed [COORD_WIDTH+sfc_pkg::VIEW_EXTRA-1:0] view_y,
  input  logic signed [COORD_WIDTH+sfc_pkg::VIEW_EXTRA-1:0] view_z,
  input  logic [COORD_WIDTH-1:0]                            radius,
  input  sfc_pkg::plane_cfg_t                               planes,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [5:0][COORD_WIDTH+sfc_pkg::DIST_EXTRA-1:0]   plane_dist,
  output logic [COORD_WIDTH-1:0]                            radius_out,
  output logic [sfc_pkg::DEPTH_W-1:0]                       depth_out
);
  import sfc_pkg::*;

  localparam int VIEW_W = COORD_WIDTH + VIEW_EXTRA;
  localparam int PW     = VIEW_W + COEF_W;
  localparam int NW     = VIEW_W + 1;
  localparam int DW     = COORD_WIDTH + DIST_EXTRA;
  localparam int EW     = VIEW_W + DEPTH_W;
  localparam logic signed [EW-1:0] SAT_HI = EW'(DEPTH_MAX);
  localparam logic signed [EW-1:0] SAT_LO = EW'(DEPTH_MIN);

  logic signed [PW-1:0]     prod_nxt [8];
  logic signed [PW-1:0]     prod_r   [8];
  logic signed [NW-1:0]     near_nxt;
  logic signed [NW-1:0]     far_nxt;
  logic signed [NW-1:0]     near_r;
  logic signed [NW-1:0]     far_r;
  logic signed [EW-1:0]     z_ext;
  logic [DEPTH_W-1:0]       depth_nxt;
  logic [DEPTH_W-1:0]       depth3_r;
  logic [DEPTH_W-1:0]       depth4_r;
  logic [COORD_WIDTH-1:0]   rad3_r;
  logic [COORD_WIDTH-1:0]   rad4_r;
  logic [5:0][DW-1:0]       dist_nxt;
  logic [5:0][DW-1:0]       dist_r;
  logic                     s3_valid_r;
  logic                     s4_valid_r;
  logic                     en3;
  logic                     en4;

  assign en4      = !s4_valid_r || out_ready;
  assign en3      = !s3_valid_r || en4;
  assign in_ready = en3;

  // Side plane products: bottom, top, left, right
  always_comb begin
    prod_nxt[0] = $signed(planes.vertical[0]) * view_z;
    prod_nxt[1] = $signed(planes.vertical[1]) * view_y;
    prod_nxt[2] = $signed(planes.vertical[3]) * view_y;
    prod_nxt[3] = $signed(planes.vertical[2]) * view_z;
    prod_nxt[4] = $signed(planes.side[0])     * view_z;
    prod_nxt[5] = $signed(planes.side[1])     * view_x;
    prod_nxt[6] = $signed(planes.side[3])     * view_x;
    prod_nxt[7] = $signed(planes.side[2])     * view_z;
  end

  // Near and far at Q.4, depth saturated to the result width
  always_comb begin
    near_nxt = -NW'(view_z) - NW'(planes.depth.near_d);
    far_nxt  = NW'(planes.depth.far_d) + NW'(view_z);
    z_ext    = EW'(view_z);
    if (z_ext > SAT_HI) begin
      depth_nxt = SAT_HI[DEPTH_W-1:0];
    end else if (z_ext < SAT_LO) begin
      depth_nxt = SAT_LO[DEPTH_W-1:0];
    end else begin
      depth_nxt = z_ext[DEPTH_W-1:0];
    end
  end

  // Six distances at Q.18
  always_comb begin
    dist_nxt[0] = DW'(near_r) <<< FRAC_BITS;
    dist_nxt[1] = DW'(far_r) <<< FRAC_BITS;
    dist_nxt[2] = DW'(prod_r[0]) - DW'(prod_r[1]);
    dist_nxt[3] = DW'(prod_r[2]) - DW'(prod_r[3]);
    dist_nxt[4] = DW'(prod_r[4]) - DW'(prod_r[5]);
    dist_nxt[5] = DW'(prod_r[6]) - DW'(prod_r[7]);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (en3) s3_valid_r <= in_valid;
      if (en4) s4_valid_r <= s3_valid_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en3) begin
      prod_r   <= prod_nxt;
      near_r   <= near_nxt;
      far_r    <= far_nxt;
      depth3_r <= depth_nxt;
      rad3_r   <= radius;
    end
    if (en4) begin
      dist_r   <= dist_nxt;
      depth4_r <= depth3_r;
      rad4_r   <= rad3_r;
    end
  end

  assign out_valid  = s4_valid_r;
  assign plane_dist = dist_r;
  assign radius_out = rad4_r;
  assign depth_out  = depth4_r;

endmodule

### hw/rtl/sfc_classify.sv
// Compares the six distances against the radius and holds the result transaction.
module sfc_classify #(
  parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic [5:0][COORD_WIDTH+sfc_pkg::DIST_EXTRA-1:0] plane_dist,
  input  logic [COORD_WIDTH-1:0]                          radius,
  input  logic [sfc_pkg::DEPTH_W-1:0]                     depth,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [sfc_pkg::VIS_W-1:0]                       visibility,
  output logic [sfc_pkg::DEPTH_W-1:0]                     view_depth
);
  import sfc_pkg::*;

  localparam int DW = COORD_WIDTH + DIST_EXTRA;

  logic signed [DW-1:0] rad_pos;
  logic signed [DW-1:0] rad_neg;
  logic                 outside;
  logic                 all_in;
  vis_t                 vis_nxt;
  vis_t                 vis_r;
  logic [DEPTH_W-1:0]   depth_r;
  logic                 valid_r;
  logic                 en;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  // Radius at Q.18; a distance equal to either bound counts as partial
  always_comb begin
    rad_pos = DW'(radius) << FRAC_BITS;
    rad_neg = -rad_pos;
    outside = 1'b0;
    all_in  = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if ($signed(plane_dist[i]) < rad_neg) outside = 1'b1;
      if (!($signed(plane_dist[i]) > rad_pos)) all_in = 1'b0;
    end
    if (outside) begin
      vis_nxt = VIS_OUTSIDE;
    end else if (all_in) begin
      vis_nxt = VIS_INSIDE;
    end else begin
      vis_nxt = VIS_PARTIAL;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r   <= vis_nxt;
      depth_r <= depth;
    end
  end

  assign out_valid  = valid_r;
  assign visibility = vis_r;
  assign view_depth = depth_r;

endmodule

### hw/rtl/sphere_frustum_classify_top.sv
// Bounding-sphere view-frustum classifier, top level.
// Each input transaction carries one sphere (centre and radius, Q12.4) and gives
// exactly one result transaction: visibility (0 outside, 1 fully inside, 2 partial)
// and the view-space depth saturated to 20 bits. The datapath is a five-stage
// pipeline (coefficient products, transform sums, plane products, plane distances,
// classification and output register), and a new sphere is taken every cycle
// while out_tready is high.
// A low out_tready holds the pipeline in place; bubbles ahead of the stall still
// fill, so no item is lost or repeated. Configuration registers feed the datapath
// directly and are meant to change only while no sphere is in flight.
module sphere_frustum_classify_top #(
  parameter int COORD_WIDTH = sfc_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: center_x, center_y, center_z, radius (COORD_WIDTH bits each), zero pad
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // out_tdata: visibility [1:0], view_depth [21:2], zero pad
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sfc_pkg::OUT_W-1:0]          out_tdata,
  input  logic                               cfg_we,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sfc_pkg::*;

  localparam int VIEW_W = COORD_WIDTH + VIEW_EXTRA;
  localparam int DW     = COORD_WIDTH + DIST_EXTRA;

  // Configuration registers
  row_t       xform_x_r;
  row_t       xform_y_r;
  row_t       xform_z_r;
  quad_t      side_r;
  quad_t      vertical_r;
  depth_rng_t depth_rng_r;
  xform_cfg_t xform_cfg;
  plane_cfg_t plane_cfg;

  // Inter-stage signals
  logic                     xf_valid;
  logic                     xf_ready;
  logic signed [VIEW_W-1:0] view_x;
  logic signed [VIEW_W-1:0] view_y;
  logic signed [VIEW_W-1:0] view_z;
  logic [COORD_WIDTH-1:0]   xf_radius;
  logic                     pl_valid;
  logic                     pl_ready;
  logic [5:0][DW-1:0]       plane_dist;
  logic [COORD_WIDTH-1:0]   pl_radius;
  logic [DEPTH_W-1:0]       pl_depth;
  logic [VIS_W-1:0]         visibility;
  logic [DEPTH_W-1:0]       view_depth;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xform_x_r   <= '0;
      xform_y_r   <= '0;
      xform_z_r   <= '0;
      side_r      <= '0;
      vertical_r  <= '0;
      depth_rng_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_XFORM_X:   xform_x_r   <= row_t'(cfg_data);
        CFG_XFORM_Y:   xform_y_r   <= row_t'(cfg_data);
        CFG_XFORM_Z:   xform_z_r   <= row_t'(cfg_data);
        CFG_SIDE:      side_r      <= quad_t'(cfg_data);
        CFG_VERTICAL:  vertical_r  <= quad_t'(cfg_data);
        CFG_DEPTH_RNG: depth_rng_r <= depth_rng_t'(cfg_data[2*COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  assign xform_cfg.row_x    = xform_x_r;
  assign xform_cfg.row_y    = xform_y_r;
  assign xform_cfg.row_z    = xform_z_r;
  assign plane_cfg.side     = side_r;
  assign plane_cfg.vertical = vertical_r;
  assign plane_cfg.depth    = depth_rng_r;

  // Transform stages
  sfc_xform #(.COORD_WIDTH(COORD_WIDTH)) u_xform (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .center_x   ($signed(in_tdata[COORD_WIDTH-1:0])),
    .center_y   ($signed(in_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
    .center_z   ($signed(in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
    .radius     (in_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
    .xform      (xform_cfg),
    .out_valid  (xf_valid),
    .out_ready  (xf_ready),
    .view_x     (view_x),
    .view_y     (view_y),
    .view_z     (view_z),
    .radius_out (xf_radius)
  );

  // Plane distance stages
  sfc_planes #(.COORD_WIDTH(COORD_WIDTH)) u_planes (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (xf_valid),
    .in_ready   (xf_ready),
    .view_x     (view_x),
    .view_y     (view_y),
    .view_z     (view_z),
    .radius     (xf_radius),
    .planes     (plane_cfg),
    .out_valid  (pl_valid),
    .out_ready  (pl_ready),
    .plane_dist (plane_dist),
    .radius_out (pl_radius),
    .depth_out  (pl_depth)
  );

  // Classification and output register
  sfc_classify #(.COORD_WIDTH(COORD_WIDTH)) u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pl_valid),
    .in_ready   (pl_ready),
    .plane_dist (plane_dist),
    .radius     (pl_radius),
    .depth      (pl_depth),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .visibility (visibility),
    .view_depth (view_depth)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, view_depth, visibility};

endmodule
